@@ rtl/lops_pkg.sv @@
// Shared types and constants for the linear overlay peer step block.
// Used by every module under rtl but lops_queue; depends on nothing else.
package lops_pkg;

   // Default widths of node ids and round numbers.
   localparam int ID_WIDTH_DEFAULT = 16;
   localparam int ROUND_WIDTH_DEFAULT = 32;

   // Fixed widths of statistics and configuration words.
   localparam int CFG_ID_WIDTH = 16;
   localparam int SEQ_WIDTH = 32;
   localparam int COUNT_WIDTH = 32;
   localparam int LAT_WIDTH = 64;

   // Depth of the command queue and of the result queue.
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Register port geometry.
   localparam int APB_DATA_WIDTH = 32;
   localparam int APB_ADDR_WIDTH = 4;

   // Register reset values.
   localparam logic [CFG_ID_WIDTH-1:0] OWN_ID_RESET = 16'd1;
   localparam logic [CFG_ID_WIDTH-1:0] INITIAL_LEFT_RESET = 16'd0;
   localparam logic [CFG_ID_WIDTH-1:0] INITIAL_RIGHT_RESET = 16'd0;
   localparam logic LEAVING_MODE_RESET = 1'b0;

   // Message actions, shared by received and sent words.
   typedef enum logic [2:0] {
      OP_ROUTE = 3'd0,
      OP_JOIN  = 3'd1,
      OP_LEAVE = 3'd2,
      OP_SUA   = 3'd3,
      OP_SUB   = 3'd4,
      OP_TDA   = 3'd5,
      OP_TDB   = 3'd6,
      OP_FTD   = 3'd7
   } op_type;

   // Kind of the splice this node has started.
   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_JOIN  = 2'd1,
      KIND_LEAVE = 2'd2
   } kind_type;

   // Register indexes (byte address divided by four).
   typedef enum logic [1:0] {
      CSR_OWN_ID        = 2'd0,
      CSR_INITIAL_LEFT  = 2'd1,
      CSR_INITIAL_RIGHT = 2'd2,
      CSR_LEAVING_MODE  = 2'd3
   } csr_index_type;

   // Configuration seen by the datapath.
   typedef struct packed {
      logic [CFG_ID_WIDTH-1:0] own_id;
      logic                    leaving_mode;
   } csr_cfg_type;

   // Classification of a word, made by the front part.
   typedef struct packed {
      op_type opcode;
      logic   req_eq_me;
      logic   req_lt_me;
      logic   me_lt_req;
      logic   leaving;
   } cmd_flags_type;

   // Control part of a result word.
   typedef struct packed {
      logic   send_valid;
      op_type send_opcode;
      logic   dropped;
      logic   satisfied;
   } rsp_flags_type;

endpackage

@@ rtl/lops_queue.sv @@
// Small first-in first-out queue of flat words.
// Used for the command queue and the result queue; depends on nothing else.
module lops_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]     mem [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == CNT_WIDTH'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset; the count guards it.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/lops_csr.sv @@
// Configuration registers behind the APB-style port.
// Depends on lops_pkg for register indexes, reset values and the config struct.
module lops_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lops_pkg::APB_ADDR_WIDTH-1:0] paddr,
   input  logic [lops_pkg::APB_DATA_WIDTH-1:0] pwdata,
   output logic [lops_pkg::APB_DATA_WIDTH-1:0] prdata,
   output logic                                pready,
   output lops_pkg::csr_cfg_type               cfg
);

   logic [lops_pkg::CFG_ID_WIDTH-1:0] own_id_ff;
   logic [lops_pkg::CFG_ID_WIDTH-1:0] initial_left_ff;
   logic [lops_pkg::CFG_ID_WIDTH-1:0] initial_right_ff;
   logic                              leaving_mode_ff;
   logic                              write_en;
   lops_pkg::csr_index_type           index;

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite;
   assign index    = lops_pkg::csr_index_type'(paddr[lops_pkg::APB_ADDR_WIDTH-1:2]);

   // Register writes in the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff        <= lops_pkg::OWN_ID_RESET;
         initial_left_ff  <= lops_pkg::INITIAL_LEFT_RESET;
         initial_right_ff <= lops_pkg::INITIAL_RIGHT_RESET;
         leaving_mode_ff  <= lops_pkg::LEAVING_MODE_RESET;
      end else if (write_en) begin
         unique case (index)
            lops_pkg::CSR_OWN_ID: begin
               own_id_ff <= pwdata[lops_pkg::CFG_ID_WIDTH-1:0];
            end
            lops_pkg::CSR_INITIAL_LEFT: begin
               initial_left_ff <= pwdata[lops_pkg::CFG_ID_WIDTH-1:0];
            end
            lops_pkg::CSR_INITIAL_RIGHT: begin
               initial_right_ff <= pwdata[lops_pkg::CFG_ID_WIDTH-1:0];
            end
            lops_pkg::CSR_LEAVING_MODE: begin
               leaving_mode_ff <= pwdata[0];
            end
         endcase
      end
   end

   // Read mux.
   always_comb begin
      unique case (index)
         lops_pkg::CSR_OWN_ID:        prdata = lops_pkg::APB_DATA_WIDTH'(own_id_ff);
         lops_pkg::CSR_INITIAL_LEFT:  prdata = lops_pkg::APB_DATA_WIDTH'(initial_left_ff);
         lops_pkg::CSR_INITIAL_RIGHT: prdata = lops_pkg::APB_DATA_WIDTH'(initial_right_ff);
         lops_pkg::CSR_LEAVING_MODE:  prdata = lops_pkg::APB_DATA_WIDTH'(leaving_mode_ff);
      endcase
   end

   assign cfg.own_id       = own_id_ff;
   assign cfg.leaving_mode = leaving_mode_ff;

endmodule

@@ rtl/lops_front.sv @@
// Front part: accepts input words, classifies them against this node's id,
// works out the latency and queues them. Depends on lops_pkg and lops_queue.
module lops_front #(
   parameter int ID_WIDTH    = lops_pkg::ID_WIDTH_DEFAULT,
   parameter int ROUND_WIDTH = lops_pkg::ROUND_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH = lops_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic [2:0]              req_opcode,
   input  logic [ID_WIDTH-1:0]     req_source_id,
   input  logic [ID_WIDTH-1:0]     req_req_id,
   input  logic [ID_WIDTH-1:0]     req_right_hint,
   input  logic [ROUND_WIDTH-1:0]  req_round_submitted,
   input  logic [ROUND_WIDTH-1:0]  req_current_round,
   input  lops_pkg::csr_cfg_type   cfg,
   input  logic                    cmd_pop,
   output logic                    cmd_empty,
   output lops_pkg::cmd_flags_type cmd_flags,
   output logic [ID_WIDTH-1:0]     cmd_src,
   output logic [ID_WIDTH-1:0]     cmd_req,
   output logic [ID_WIDTH-1:0]     cmd_hint,
   output logic [ROUND_WIDTH-1:0]  cmd_round,
   output logic [ROUND_WIDTH-1:0]  cmd_lat
);

   localparam int CMD_WIDTH = $bits(lops_pkg::cmd_flags_type) + 3 * ID_WIDTH
                              + 2 * ROUND_WIDTH;

   logic [ID_WIDTH-1:0]     me;
   lops_pkg::cmd_flags_type flags;
   logic [ROUND_WIDTH-1:0]  lat;
   logic [CMD_WIDTH-1:0]    push_word;
   logic [CMD_WIDTH-1:0]    pop_word;

   // Classify the word against this node's own id.
   always_comb begin
      me              = ID_WIDTH'(cfg.own_id);
      flags.opcode    = lops_pkg::op_type'(req_opcode);
      flags.req_eq_me = (req_req_id == me);
      flags.req_lt_me = (req_req_id < me);
      flags.me_lt_req = (me < req_req_id);
      flags.leaving   = cfg.leaving_mode;
   end

   // Latency in rounds, floored at zero.
   always_comb begin
      if (req_current_round > req_round_submitted) begin
         lat = req_current_round - req_round_submitted - 1'b1;
      end else begin
         lat = '0;
      end
   end

   assign push_word = {flags, req_source_id, req_req_id, req_right_hint,
                       req_round_submitted, lat};

   lops_queue #(
      .WIDTH (CMD_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_word),
      .full      (full),
      .pop       (cmd_pop),
      .pop_data  (pop_word),
      .empty     (cmd_empty)
   );

   assign {cmd_flags, cmd_src, cmd_req, cmd_hint, cmd_round, cmd_lat} = pop_word;

endmodule

@@ rtl/lops_back.sv @@
// Back part: carries out queued words against the neighbor state and the
// statistics, and queues one result word each. Depends on lops_pkg and lops_queue.
module lops_back #(
   parameter int ID_WIDTH    = lops_pkg::ID_WIDTH_DEFAULT,
   parameter int ROUND_WIDTH = lops_pkg::ROUND_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH = lops_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 cmd_empty,
   output logic                                 cmd_pop,
   input  lops_pkg::cmd_flags_type              cmd_flags,
   input  logic [ID_WIDTH-1:0]                  cmd_src,
   input  logic [ID_WIDTH-1:0]                  cmd_req,
   input  logic [ID_WIDTH-1:0]                  cmd_hint,
   input  logic [ROUND_WIDTH-1:0]               cmd_round,
   input  logic [ROUND_WIDTH-1:0]               cmd_lat,
   output logic                                 empty,
   input  logic                                 pop,
   output logic                                 rsp_send_valid,
   output logic [ID_WIDTH-1:0]                  rsp_send_dest,
   output logic [2:0]                           rsp_send_opcode,
   output logic [ID_WIDTH-1:0]                  rsp_send_req_id,
   output logic [ID_WIDTH-1:0]                  rsp_send_right_hint,
   output logic [ROUND_WIDTH-1:0]               rsp_send_round,
   output logic [lops_pkg::SEQ_WIDTH-1:0]       rsp_packet_seq,
   output logic                                 rsp_dropped,
   output logic                                 rsp_satisfied,
   output logic [lops_pkg::COUNT_WIDTH-1:0]     rsp_total_satisfied,
   output logic [lops_pkg::LAT_WIDTH-1:0]       rsp_total_latency
);

   localparam int RSP_WIDTH = $bits(lops_pkg::rsp_flags_type) + 3 * ID_WIDTH
                              + ROUND_WIDTH + lops_pkg::SEQ_WIDTH
                              + lops_pkg::COUNT_WIDTH + lops_pkg::LAT_WIDTH;
   localparam logic [ID_WIDTH-1:0] END_ID = '1;

   // Neighbor state and statistics.
   logic [ID_WIDTH-1:0]              left_ff, left_in;
   logic [ID_WIDTH-1:0]              right_ff, right_in;
   logic                             busy_ff, busy_in;
   lops_pkg::kind_type               kind_ff, kind_in;
   logic [lops_pkg::SEQ_WIDTH-1:0]   counter_ff, counter_in;
   logic [lops_pkg::COUNT_WIDTH-1:0] sat_ff, sat_in;
   logic [lops_pkg::LAT_WIDTH-1:0]   lat_ff, lat_in;

   logic                   fire;
   logic                   rsp_full;
   logic                   attempt;
   logic                   done;
   logic                   send_ok;
   logic [ID_WIDTH-1:0]    dest;
   lops_pkg::op_type       sop;
   logic [ID_WIDTH-1:0]    sreq;
   logic [ID_WIDTH-1:0]    shint;
   logic [ID_WIDTH-1:0]    route_dest;
   logic                   req_lt_right;
   lops_pkg::rsp_flags_type rsp_flags_in;
   lops_pkg::rsp_flags_type rsp_flags_out;
   logic [RSP_WIDTH-1:0]   push_word;
   logic [RSP_WIDTH-1:0]   pop_word;
   logic [ID_WIDTH-1:0]    out_dest;
   logic [ID_WIDTH-1:0]    out_req;
   logic [ID_WIDTH-1:0]    out_hint;
   logic [ROUND_WIDTH-1:0] out_round;
   logic [lops_pkg::SEQ_WIDTH-1:0] out_seq;

   assign fire    = !cmd_empty && !rsp_full;
   assign cmd_pop = fire;

   assign req_lt_right = (cmd_req < right_ff);
   assign route_dest   = cmd_flags.req_lt_me ? left_ff : right_ff;

   // Protocol action for the word at the head of the command queue.
   always_comb begin
      attempt  = 1'b0;
      done     = 1'b0;
      dest     = '0;
      sop      = cmd_flags.opcode;
      sreq     = cmd_req;
      shint    = cmd_hint;
      left_in  = left_ff;
      right_in = right_ff;
      busy_in  = busy_ff;
      kind_in  = kind_ff;
      unique case (cmd_flags.opcode)
         lops_pkg::OP_ROUTE: begin
            if (cmd_flags.req_eq_me || (cmd_flags.me_lt_req && req_lt_right)) begin
               done = 1'b1;
            end else begin
               attempt = 1'b1;
               dest    = route_dest;
            end
         end
         lops_pkg::OP_JOIN: begin
            attempt = 1'b1;
            if (cmd_flags.me_lt_req && req_lt_right && !cmd_flags.leaving
                && !busy_ff) begin
               sop     = lops_pkg::OP_SUA;
               sreq    = right_ff;
               dest    = cmd_req;
               kind_in = lops_pkg::KIND_JOIN;
               busy_in = 1'b1;
            end else begin
               dest = route_dest;
            end
         end
         lops_pkg::OP_LEAVE: begin
            attempt = 1'b1;
            if ((cmd_req == right_ff) && !cmd_flags.leaving && !busy_ff) begin
               sop     = lops_pkg::OP_SUA;
               sreq    = '0;
               dest    = cmd_hint;
               kind_in = lops_pkg::KIND_LEAVE;
               busy_in = 1'b1;
            end else if (cmd_flags.req_eq_me) begin
               shint = right_ff;
               dest  = left_ff;
            end else begin
               dest = route_dest;
            end
         end
         lops_pkg::OP_SUA: begin
            attempt = 1'b1;
            left_in = cmd_src;
            if (cmd_req != '0) begin
               right_in = cmd_req;
               sreq     = '0;
               dest     = cmd_req;
            end else begin
               sop  = lops_pkg::OP_SUB;
               dest = cmd_src;
            end
         end
         lops_pkg::OP_SUB: begin
            attempt = 1'b1;
            if (cmd_src != right_ff) begin
               sop      = lops_pkg::OP_TDA;
               dest     = right_ff;
               right_in = cmd_src;
            end else begin
               dest = left_ff;
            end
         end
         lops_pkg::OP_TDA: begin
            attempt = 1'b1;
            if (cmd_src != left_ff) begin
               sop  = lops_pkg::OP_TDB;
               dest = cmd_src;
            end else begin
               dest = right_ff;
            end
         end
         lops_pkg::OP_TDB: begin
            attempt = 1'b1;
            if (cmd_src != right_ff) begin
               sop     = lops_pkg::OP_FTD;
               dest    = (kind_ff == lops_pkg::KIND_LEAVE) ? cmd_src : right_ff;
               kind_in = lops_pkg::KIND_NONE;
               busy_in = 1'b0;
            end else begin
               dest = left_ff;
            end
         end
         lops_pkg::OP_FTD: begin
            if (cmd_flags.leaving) begin
               right_in = '0;
               left_in  = '0;
            end else begin
               busy_in = 1'b0;
            end
            done = 1'b1;
         end
      endcase
   end

   // Drop sends to the empty id or the end sentinel; count the rest.
   always_comb begin
      send_ok    = attempt && (dest != '0) && (dest != END_ID);
      counter_in = counter_ff + lops_pkg::SEQ_WIDTH'(send_ok);
      sat_in     = sat_ff + lops_pkg::COUNT_WIDTH'(done);
      lat_in     = done ? lat_ff + lops_pkg::LAT_WIDTH'(cmd_lat) : lat_ff;
      out_dest   = send_ok ? dest : '0;
      out_req    = send_ok ? sreq : '0;
      out_hint   = send_ok ? shint : '0;
      out_round  = send_ok ? cmd_round : '0;
      out_seq    = send_ok ? counter_ff : '0;
      rsp_flags_in.send_valid  = send_ok;
      rsp_flags_in.send_opcode = send_ok ? sop : lops_pkg::OP_ROUTE;
      rsp_flags_in.dropped     = attempt && !send_ok;
      rsp_flags_in.satisfied   = done;
   end

   // State registers advance only when a word is carried out.
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff    <= ID_WIDTH'(lops_pkg::INITIAL_LEFT_RESET);
         right_ff   <= ID_WIDTH'(lops_pkg::INITIAL_RIGHT_RESET);
         busy_ff    <= 1'b0;
         kind_ff    <= lops_pkg::KIND_NONE;
         counter_ff <= '0;
         sat_ff     <= '0;
         lat_ff     <= '0;
      end else if (fire) begin
         left_ff    <= left_in;
         right_ff   <= right_in;
         busy_ff    <= busy_in;
         kind_ff    <= kind_in;
         counter_ff <= counter_in;
         sat_ff     <= sat_in;
         lat_ff     <= lat_in;
      end
   end

   assign push_word = {rsp_flags_in, out_dest, out_req, out_hint, out_round,
                       out_seq, sat_in, lat_in};

   lops_queue #(
      .WIDTH (RSP_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .push_data (push_word),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (pop_word),
      .empty     (empty)
   );

   assign {rsp_flags_out, rsp_send_dest, rsp_send_req_id, rsp_send_right_hint,
           rsp_send_round, rsp_packet_seq, rsp_total_satisfied,
           rsp_total_latency} = pop_word;
   assign rsp_send_valid  = rsp_flags_out.send_valid;
   assign rsp_send_opcode = rsp_flags_out.send_opcode;
   assign rsp_dropped     = rsp_flags_out.dropped;
   assign rsp_satisfied   = rsp_flags_out.satisfied;

endmodule

@@ rtl/linear_overlay_peer_step.sv @@
// Linear overlay peer step: top level joining registers, front and back parts.
// A pushed word waits in the command queue; the back part carries it out and queues its result word.
// Throughput: one word per cycle while the command queue holds a word and the result queue has room.
// The command and result queues, QUEUE_DEPTH words each (two by default), let either side stall alone.
// Reset is synchronous and active high: queues empty, neighbors 0, own_id 1.
// Depends on lops_pkg, lops_csr, lops_front, lops_back and lops_queue.
module linear_overlay_peer_step #(
   parameter int ID_WIDTH    = lops_pkg::ID_WIDTH_DEFAULT,
   parameter int ROUND_WIDTH = lops_pkg::ROUND_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH = lops_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // Configuration port.
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lops_pkg::APB_ADDR_WIDTH-1:0] paddr,
   input  logic [lops_pkg::APB_DATA_WIDTH-1:0] pwdata,
   output logic [lops_pkg::APB_DATA_WIDTH-1:0] prdata,
   output logic                                pready,
   // Input words.
   input  logic                                push,
   output logic                                full,
   input  logic [2:0]                          req_opcode,
   input  logic [ID_WIDTH-1:0]                 req_source_id,
   input  logic [ID_WIDTH-1:0]                 req_req_id,
   input  logic [ID_WIDTH-1:0]                 req_right_hint,
   input  logic [ROUND_WIDTH-1:0]              req_round_submitted,
   input  logic [ROUND_WIDTH-1:0]              req_current_round,
   // Result words.
   output logic                                empty,
   input  logic                                pop,
   output logic                                rsp_send_valid,
   output logic [ID_WIDTH-1:0]                 rsp_send_dest,
   output logic [2:0]                          rsp_send_opcode,
   output logic [ID_WIDTH-1:0]                 rsp_send_req_id,
   output logic [ID_WIDTH-1:0]                 rsp_send_right_hint,
   output logic [ROUND_WIDTH-1:0]              rsp_send_round,
   output logic [lops_pkg::SEQ_WIDTH-1:0]      rsp_packet_seq,
   output logic                                rsp_dropped,
   output logic                                rsp_satisfied,
   output logic [lops_pkg::COUNT_WIDTH-1:0]    rsp_total_satisfied,
   output logic [lops_pkg::LAT_WIDTH-1:0]      rsp_total_latency
);

   lops_pkg::csr_cfg_type   cfg;
   logic                    cmd_pop;
   logic                    cmd_empty;
   lops_pkg::cmd_flags_type cmd_flags;
   logic [ID_WIDTH-1:0]     cmd_src;
   logic [ID_WIDTH-1:0]     cmd_req;
   logic [ID_WIDTH-1:0]     cmd_hint;
   logic [ROUND_WIDTH-1:0]  cmd_round;
   logic [ROUND_WIDTH-1:0]  cmd_lat;

   lops_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lops_front #(
      .ID_WIDTH    (ID_WIDTH),
      .ROUND_WIDTH (ROUND_WIDTH),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_opcode          (req_opcode),
      .req_source_id       (req_source_id),
      .req_req_id          (req_req_id),
      .req_right_hint      (req_right_hint),
      .req_round_submitted (req_round_submitted),
      .req_current_round   (req_current_round),
      .cfg                 (cfg),
      .cmd_pop             (cmd_pop),
      .cmd_empty           (cmd_empty),
      .cmd_flags           (cmd_flags),
      .cmd_src             (cmd_src),
      .cmd_req             (cmd_req),
      .cmd_hint            (cmd_hint),
      .cmd_round           (cmd_round),
      .cmd_lat             (cmd_lat)
   );

   lops_back #(
      .ID_WIDTH    (ID_WIDTH),
      .ROUND_WIDTH (ROUND_WIDTH),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .cmd_empty           (cmd_empty),
      .cmd_pop             (cmd_pop),
      .cmd_flags           (cmd_flags),
      .cmd_src             (cmd_src),
      .cmd_req             (cmd_req),
      .cmd_hint            (cmd_hint),
      .cmd_round           (cmd_round),
      .cmd_lat             (cmd_lat),
      .empty               (empty),
      .pop                 (pop),
      .rsp_send_valid      (rsp_send_valid),
      .rsp_send_dest       (rsp_send_dest),
      .rsp_send_opcode     (rsp_send_opcode),
      .rsp_send_req_id     (rsp_send_req_id),
      .rsp_send_right_hint (rsp_send_right_hint),
      .rsp_send_round      (rsp_send_round),
      .rsp_packet_seq      (rsp_packet_seq),
      .rsp_dropped         (rsp_dropped),
      .rsp_satisfied       (rsp_satisfied),
      .rsp_total_satisfied (rsp_total_satisfied),
      .rsp_total_latency   (rsp_total_latency)
   );

   // After reset both queues are empty: no result shown and room for a word.
   a_reset_clears_queues : assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not cleared by reset");

   // A word that is sent never goes to the empty id.
   a_sent_dest_nonzero : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_send_valid) |-> (rsp_send_dest != '0))
      else $error("sent word addressed to the empty id");

   // A word that completes a request neither sends nor drops a message.
   a_satisfied_no_send : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_satisfied) |-> (!rsp_send_valid && !rsp_dropped))
      else $error("completed request also sends or drops");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the linear overlay peer step block.
// Drives message words and register writes, and predicts every result word in place.
// Depends on lops_pkg and linear_overlay_peer_step.
module testbench;

   // One result word as the block presents it.
   typedef struct packed {
      logic             send_valid;
      logic [15:0]      send_dest;
      lops_pkg::op_type send_opcode;
      logic [15:0]      send_req_id;
      logic [15:0]      send_right_hint;
      logic [31:0]      send_round;
      logic [31:0]      packet_seq;
      logic             dropped;
      logic             satisfied;
      logic [31:0]      total_satisfied;
      logic [63:0]      total_latency;
   } outcome_type;

   // One message word, with a typed-in result where it is known at a glance.
   typedef struct packed {
      lops_pkg::op_type opcode;
      logic [15:0]      src;
      logic [15:0]      req;
      logic [15:0]      hint;
      logic [31:0]      rsub;
      logic [31:0]      now;
      logic             known;
      outcome_type      outcome;
   } msg_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [lops_pkg::APB_ADDR_WIDTH-1:0] paddr = '0;
   logic [lops_pkg::APB_DATA_WIDTH-1:0] pwdata = '0;
   logic [lops_pkg::APB_DATA_WIDTH-1:0] prdata;
   logic        pready;
   logic        push = 1'b0;
   logic        full;
   logic [2:0]  req_opcode = '0;
   logic [15:0] req_source_id = '0;
   logic [15:0] req_req_id = '0;
   logic [15:0] req_right_hint = '0;
   logic [31:0] req_round_submitted = '0;
   logic [31:0] req_current_round = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic        rsp_send_valid;
   logic [15:0] rsp_send_dest;
   logic [2:0]  rsp_send_opcode;
   logic [15:0] rsp_send_req_id;
   logic [15:0] rsp_send_right_hint;
   logic [31:0] rsp_send_round;
   logic [31:0] rsp_packet_seq;
   logic        rsp_dropped;
   logic        rsp_satisfied;
   logic [31:0] rsp_total_satisfied;
   logic [63:0] rsp_total_latency;

   // Configuration and state of the predicted peer.
   logic [15:0]        cfg_own_id;
   logic [15:0]        cfg_init_left;
   logic [15:0]        cfg_init_right;
   logic               cfg_leaving;
   logic [15:0]        nb_left;
   logic [15:0]        nb_right;
   logic               peer_busy;
   lops_pkg::kind_type splice_kind;
   logic [31:0]        pkt_count;
   logic [31:0]        done_count;
   logic [63:0]        lat_total;

   outcome_type awaited_outcomes[$];
   msg_row_type directed_rows[$];
   int          mismatch_count = 0;
   int          sender_idle_pct = 24;
   int          receiver_idle_pct = 59;
   bit          hold_request = 1'b0;

   linear_overlay_peer_step DUT (
      .clock(clock), .reset(reset),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .push(push), .full(full),
      .req_opcode(req_opcode), .req_source_id(req_source_id),
      .req_req_id(req_req_id), .req_right_hint(req_right_hint),
      .req_round_submitted(req_round_submitted),
      .req_current_round(req_current_round),
      .empty(empty), .pop(pop),
      .rsp_send_valid(rsp_send_valid), .rsp_send_dest(rsp_send_dest),
      .rsp_send_opcode(rsp_send_opcode), .rsp_send_req_id(rsp_send_req_id),
      .rsp_send_right_hint(rsp_send_right_hint), .rsp_send_round(rsp_send_round),
      .rsp_packet_seq(rsp_packet_seq), .rsp_dropped(rsp_dropped),
      .rsp_satisfied(rsp_satisfied), .rsp_total_satisfied(rsp_total_satisfied),
      .rsp_total_latency(rsp_total_latency)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #3000000;
      $display("end of test: mismatches");
      $finish;
   end

   // Works out the result word of one message and advances the predicted peer.
   function automatic outcome_type overlay_outcome(msg_row_type m);
      outcome_type      o;
      logic             attempt;
      logic             done;
      logic [15:0]      dest;
      logic [15:0]      sreq;
      logic [15:0]      shint;
      logic [31:0]      lat;
      lops_pkg::op_type sop;
      o = '0;
      attempt = 1'b0;
      done = 1'b0;
      dest = '0;
      sop = m.opcode;
      sreq = m.req;
      shint = m.hint;
      case (m.opcode)
         lops_pkg::OP_ROUTE: begin
            if (m.req == cfg_own_id || (cfg_own_id < m.req && m.req < nb_right)) begin
               done = 1'b1;
            end else begin
               attempt = 1'b1;
               dest = (m.req < cfg_own_id) ? nb_left : nb_right;
            end
         end
         lops_pkg::OP_JOIN: begin
            attempt = 1'b1;
            if (cfg_own_id < m.req && m.req < nb_right && !cfg_leaving && !peer_busy) begin
               sop = lops_pkg::OP_SUA;
               sreq = nb_right;
               dest = m.req;
               splice_kind = lops_pkg::KIND_JOIN;
               peer_busy = 1'b1;
            end else begin
               dest = (m.req < cfg_own_id) ? nb_left : nb_right;
            end
         end
         lops_pkg::OP_LEAVE: begin
            attempt = 1'b1;
            if (m.req == nb_right && !cfg_leaving && !peer_busy) begin
               sop = lops_pkg::OP_SUA;
               sreq = '0;
               dest = m.hint;
               splice_kind = lops_pkg::KIND_LEAVE;
               peer_busy = 1'b1;
            end else if (m.req == cfg_own_id) begin
               shint = nb_right;
               dest = nb_left;
            end else begin
               dest = (m.req < cfg_own_id) ? nb_left : nb_right;
            end
         end
         lops_pkg::OP_SUA: begin
            attempt = 1'b1;
            nb_left = m.src;
            if (m.req != 16'd0) begin
               nb_right = m.req;
               sreq = '0;
               dest = nb_right;
            end else begin
               sop = lops_pkg::OP_SUB;
               dest = nb_left;
            end
         end
         lops_pkg::OP_SUB: begin
            attempt = 1'b1;
            if (m.src != nb_right) begin
               sop = lops_pkg::OP_TDA;
               dest = nb_right;
               nb_right = m.src;
            end else begin
               dest = nb_left;
            end
         end
         lops_pkg::OP_TDA: begin
            attempt = 1'b1;
            if (m.src != nb_left) begin
               sop = lops_pkg::OP_TDB;
               dest = m.src;
            end else begin
               dest = nb_right;
            end
         end
         lops_pkg::OP_TDB: begin
            attempt = 1'b1;
            if (m.src != nb_right) begin
               sop = lops_pkg::OP_FTD;
               dest = (splice_kind == lops_pkg::KIND_LEAVE) ? m.src : nb_right;
               splice_kind = lops_pkg::KIND_NONE;
               peer_busy = 1'b0;
            end else begin
               dest = nb_left;
            end
         end
         default: begin
            // A finish while leaving detaches the node from both sides.
            if (cfg_leaving) begin
               nb_right = '0;
               nb_left = '0;
            end else begin
               peer_busy = 1'b0;
            end
            done = 1'b1;
         end
      endcase

      // Latency counts the rounds in between and never goes below zero.
      if (done) begin
         lat = (m.now > m.rsub) ? m.now - m.rsub - 32'd1 : 32'd0;
         done_count = done_count + 32'd1;
         lat_total = lat_total + {32'd0, lat};
      end

      // Sends to the empty id or the end sentinel are dropped uncounted.
      if (attempt) begin
         if (dest == 16'h0000 || dest == 16'hFFFF) begin
            o.dropped = 1'b1;
         end else begin
            o.send_valid = 1'b1;
            o.send_dest = dest;
            o.send_opcode = sop;
            o.send_req_id = sreq;
            o.send_right_hint = shint;
            o.send_round = m.rsub;
            o.packet_seq = pkt_count;
            pkt_count = pkt_count + 32'd1;
         end
      end
      o.satisfied = done;
      o.total_satisfied = done_count;
      o.total_latency = lat_total;
      return o;
   endfunction

   function automatic outcome_type tally_only(logic drop, logic sat, logic [31:0] count,
                                              logic [63:0] lat);
      outcome_type o;
      o = '0;
      o.dropped = drop;
      o.satisfied = sat;
      o.total_satisfied = count;
      o.total_latency = lat;
      return o;
   endfunction

   // Id pickers aimed at the interesting spots around this node and its neighbors.
   function automatic logic [15:0] pick_id();
      case ($urandom_range(11))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return cfg_own_id;
         3: return cfg_own_id - 16'd1;
         4: return cfg_own_id + 16'd1;
         5: return nb_left;
         6: return nb_right;
         7: return nb_right - 16'd1;
         8: return nb_right + 16'd1;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] id_between();
      int lo;
      int hi;
      lo = int'(cfg_own_id) + 1;
      hi = int'(nb_right) - 1;
      if (lo <= hi) return 16'($urandom_range(hi, lo));
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] id_below();
      return 16'($urandom_range(int'(cfg_own_id) - 1, 0));
   endfunction

   function automatic logic [15:0] id_above();
      return 16'($urandom_range(65535, int'(cfg_own_id) + 1));
   endfunction

   // Builds a message word with rounds that cover late, early and extreme values.
   function automatic msg_row_type make_msg(lops_pkg::op_type op, logic [15:0] src,
                                            logic [15:0] req, logic [15:0] hint);
      msg_row_type m;
      logic [31:0] base;
      base = $urandom;
      m = '0;
      m.opcode = op;
      m.src = src;
      m.req = req;
      m.hint = hint;
      m.rsub = base;
      case ($urandom_range(9))
         0: begin
            m.rsub = 32'd0;
            m.now = 32'hFFFF_FFFF;
         end
         1: begin
            m.rsub = 32'hFFFF_FFFF;
            m.now = $urandom;
         end
         2: m.now = base;
         3: m.now = base - $urandom_range(8, 1);
         4, 5: m.now = $urandom;
         default: m.now = base + $urandom_range(40, 1);
      endcase
      return m;
   endfunction

   task automatic add_row(lops_pkg::op_type op, logic [15:0] src, logic [15:0] req,
                          logic [15:0] hint, logic [31:0] rsub, logic [31:0] now,
                          logic known, outcome_type o);
      msg_row_type m;
      m = '{op, src, req, hint, rsub, now, known, o};
      directed_rows.insert(directed_rows.size(), m);
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Compares one accepted result word with the oldest expected one.
   task automatic check_outcome();
      outcome_type want;
      if (awaited_outcomes.size() == 0) begin
         $display("%0t: result word arrived with no expected word waiting", $time);
         mismatch_count++;
      end else begin
         want = awaited_outcomes.pop_front();
         check_field("send_valid", 64'(want.send_valid), 64'(rsp_send_valid));
         check_field("send_dest", 64'(want.send_dest), 64'(rsp_send_dest));
         check_field("send_opcode", 64'(want.send_opcode), 64'(rsp_send_opcode));
         check_field("send_req_id", 64'(want.send_req_id), 64'(rsp_send_req_id));
         check_field("send_right_hint", 64'(want.send_right_hint),
                     64'(rsp_send_right_hint));
         check_field("send_round", 64'(want.send_round), 64'(rsp_send_round));
         check_field("packet_seq", 64'(want.packet_seq), 64'(rsp_packet_seq));
         check_field("dropped", 64'(want.dropped), 64'(rsp_dropped));
         check_field("satisfied", 64'(want.satisfied), 64'(rsp_satisfied));
         check_field("total_satisfied", 64'(want.total_satisfied),
                     64'(rsp_total_satisfied));
         check_field("total_latency", want.total_latency, rsp_total_latency);
      end
   endtask

   // Offers one word, holds it until accepted, and records its expected result.
   task automatic send_word(msg_row_type m);
      outcome_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_opcode <= m.opcode;
      req_source_id <= m.src;
      req_req_id <= m.req;
      req_right_hint <= m.hint;
      req_round_submitted <= m.rsub;
      req_current_round <= m.now;
      @(posedge clock);
      while (full) @(posedge clock);
      predicted = overlay_outcome(m);
      awaited_outcomes.insert(awaited_outcomes.size(), m.known ? m.outcome : predicted);
   endtask

   // Stops offering and waits for every expected word to come back.
   task automatic drain_outcomes();
      push <= 1'b0;
      while (awaited_outcomes.size() != 0) @(posedge clock);
   endtask

   // Register write: setup cycle, access cycle, then the bus goes idle.
   task automatic csr_write(lops_pkg::csr_index_type idx, logic [31:0] value);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         lops_pkg::CSR_OWN_ID:        cfg_own_id = value[15:0];
         lops_pkg::CSR_INITIAL_LEFT:  cfg_init_left = value[15:0];
         lops_pkg::CSR_INITIAL_RIGHT: cfg_init_right = value[15:0];
         default:                     cfg_leaving = value[0];
      endcase
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly well-formed exchanges with random content, the rest noise.
   task automatic send_sequence(output int n);
      logic [15:0] far;
      case ($urandom_range(9))
         0, 1, 2: begin
            send_word(make_msg(lops_pkg::op_type'($urandom_range(7)), pick_id(), pick_id(),
                               pick_id()));
            n = 1;
         end
         3, 4: begin
            send_word(make_msg(lops_pkg::OP_SUA, id_below(), id_above(), pick_id()));
            send_word(make_msg(lops_pkg::OP_ROUTE, pick_id(), id_between(), pick_id()));
            n = 2;
         end
         5, 6: begin
            send_word(make_msg(lops_pkg::OP_JOIN, pick_id(),
                               ($urandom_range(3) != 0) ? id_between() : pick_id(), pick_id()));
            send_word(make_msg(lops_pkg::OP_SUB, $urandom_range(1) ? nb_right : pick_id(),
                               pick_id(), pick_id()));
            send_word(make_msg(lops_pkg::OP_TDA, $urandom_range(1) ? nb_left : pick_id(),
                               pick_id(), pick_id()));
            send_word(make_msg(lops_pkg::OP_TDB,
                               ($urandom_range(3) == 0) ? nb_right : pick_id(),
                               pick_id(), pick_id()));
            send_word(make_msg(lops_pkg::OP_FTD, pick_id(), pick_id(), pick_id()));
            n = 5;
         end
         7: begin
            far = id_above();
            send_word(make_msg(lops_pkg::OP_LEAVE, pick_id(), nb_right, far));
            send_word(make_msg(lops_pkg::OP_TDB, far, pick_id(), pick_id()));
            send_word(make_msg(lops_pkg::OP_FTD, pick_id(), pick_id(), pick_id()));
            n = 3;
         end
         8: begin
            send_word(make_msg(lops_pkg::OP_ROUTE, pick_id(), pick_id(), pick_id()));
            send_word(make_msg(lops_pkg::OP_ROUTE, pick_id(), id_between(), pick_id()));
            send_word(make_msg(lops_pkg::OP_ROUTE, pick_id(), pick_id(), pick_id()));
            n = 3;
         end
         default: begin
            send_word(make_msg(lops_pkg::OP_LEAVE, pick_id(), cfg_own_id, pick_id()));
            send_word(make_msg(lops_pkg::OP_SUA, pick_id(),
                               $urandom_range(1) ? 16'h0000 : pick_id(), pick_id()));
            send_word(make_msg(lops_pkg::OP_FTD, pick_id(), pick_id(), pick_id()));
            n = 3;
         end
      endcase
   endtask

   // Result side: checks accepted words and idles or holds off as asked.
   initial begin : result_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (pop && !empty) check_outcome();
            if (hold_request) begin
               hold_request = 1'b0;
               hold_left = 80;
            end
            if (hold_left > 0) begin
               hold_left--;
               pop <= 1'b0;
            end else begin
               pop <= ($urandom_range(99) >= receiver_idle_pct);
            end
         end
      end
   end

   // Input side: directed table, then random phases under several settings.
   initial begin : input_side
      int          sent;
      int          n;
      bit          held;
      bit          paused;
      logic [15:0] own;
      logic [15:0] init_l;
      logic [15:0] init_r;
      logic        lv;

      cfg_own_id = lops_pkg::OWN_ID_RESET;
      cfg_init_left = lops_pkg::INITIAL_LEFT_RESET;
      cfg_init_right = lops_pkg::INITIAL_RIGHT_RESET;
      cfg_leaving = lops_pkg::LEAVING_MODE_RESET;
      nb_left = cfg_init_left;
      nb_right = cfg_init_right;
      peer_busy = 1'b0;
      splice_kind = lops_pkg::KIND_NONE;
      pkt_count = '0;
      done_count = '0;
      lat_total = '0;
      held = 1'b0;
      paused = 1'b0;

      // After reset this node is id 1 with no neighbors at all.
      add_row(lops_pkg::OP_ROUTE, 16'h0000, 16'h0000, 16'h0000, 32'd0, 32'd0, 1'b1,
              tally_only(1'b1, 1'b0, 32'd0, 64'd0));
      add_row(lops_pkg::OP_FTD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd0, 32'hFFFF_FFFF, 1'b1,
              tally_only(1'b0, 1'b1, 32'd1, 64'hFFFF_FFFE));
      add_row(lops_pkg::OP_FTD, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 32'd0, 1'b1,
              tally_only(1'b0, 1'b1, 32'd2, 64'hFFFF_FFFE));
      add_row(lops_pkg::OP_SUA, 16'h0000, 16'h0800, 16'h1234, 32'd7, 32'd9, 1'b0, '0);
      add_row(lops_pkg::OP_JOIN, 16'h0400, 16'h0400, 16'h0000, 32'd1, 32'd2, 1'b0, '0);
      add_row(lops_pkg::OP_JOIN, 16'h0500, 16'h0500, 16'h0000, 32'd1, 32'd2, 1'b0, '0);
      add_row(lops_pkg::OP_LEAVE, 16'h0800, 16'h0800, 16'h0900, 32'd3, 32'd3, 1'b0, '0);
      add_row(lops_pkg::OP_ROUTE, 16'h0600, 16'h0600, 16'h0000, 32'd10, 32'd10, 1'b0, '0);
      add_row(lops_pkg::OP_ROUTE, 16'h0002, 16'h0001, 16'h0000, 32'd10, 32'd20, 1'b0, '0);
      add_row(lops_pkg::OP_ROUTE, 16'h0002, 16'hFFFF, 16'hFFFF, 32'd11, 32'd12, 1'b0, '0);
      add_row(lops_pkg::OP_TDB, 16'h0400, 16'h0400, 16'h0000, 32'd4, 32'd9, 1'b0, '0);
      add_row(lops_pkg::OP_LEAVE, 16'h0800, 16'h0800, 16'h0A00, 32'd5, 32'd6, 1'b0, '0);
      add_row(lops_pkg::OP_TDB, 16'h0A00, 16'h0000, 16'h0000, 32'd5, 32'd30, 1'b0, '0);
      add_row(lops_pkg::OP_LEAVE, 16'h0001, 16'h0001, 16'h0000, 32'd6, 32'd6, 1'b0, '0);
      add_row(lops_pkg::OP_SUA, 16'h0003, 16'h0000, 16'h5555, 32'd8, 32'd8, 1'b0, '0);
      add_row(lops_pkg::OP_SUB, 16'h0700, 16'h0000, 16'h0000, 32'd8, 32'd9, 1'b0, '0);
      add_row(lops_pkg::OP_SUB, 16'h0700, 16'h0000, 16'h0000, 32'd8, 32'd9, 1'b0, '0);
      add_row(lops_pkg::OP_TDA, 16'h0200, 16'h0000, 16'h0000, 32'd8, 32'd9, 1'b0, '0);
      add_row(lops_pkg::OP_TDA, 16'h0003, 16'h0000, 16'h0000, 32'd8, 32'd9, 1'b0, '0);
      add_row(lops_pkg::OP_TDB, 16'h0700, 16'h0000, 16'h0000, 32'd8, 32'd9, 1'b0, '0);
      add_row(lops_pkg::OP_SUA, 16'hFFFF, 16'h0000, 16'hAAAA, 32'hAAAA_AAAA, 32'h5555_5555,
              1'b0, '0);
      add_row(lops_pkg::OP_SUB, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd1, 32'd1, 1'b0, '0);
      add_row(lops_pkg::OP_ROUTE, 16'h0050, 16'h0050, 16'h0000, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 1'b0, '0);
      add_row(lops_pkg::OP_FTD, 16'h0000, 16'h0000, 16'h0000, 32'h7FFF_FFFF,
              32'h8000_0001, 1'b0, '0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) send_word(directed_rows[i]);

      for (int phase = 0; phase < 6; phase++) begin
         // Registers change only with the block idle.
         drain_outcomes();
         repeat (4) @(posedge clock);
         case (phase)
            0: begin
               own = 16'h8000;
               lv = 1'b0;
               init_l = 16'hFFFF;
               init_r = 16'h0000;
            end
            1: begin
               own = 16'h0001;
               lv = 1'b1;
               init_l = 16'h0000;
               init_r = 16'hFFFF;
            end
            2: begin
               own = 16'hFFFE;
               lv = 1'b0;
               init_l = 16'($urandom);
               init_r = 16'($urandom);
            end
            3: begin
               own = 16'($urandom_range(16'hFFFE, 1));
               lv = 1'b1;
               init_l = 16'($urandom);
               init_r = 16'($urandom);
            end
            4: begin
               own = 16'($urandom_range(16'hFFFE, 1));
               lv = 1'b0;
               init_l = 16'h0001;
               init_r = 16'hFFFE;
            end
            default: begin
               own = 16'h7FFF;
               lv = 1'b0;
               init_l = 16'hFFFF;
               init_r = 16'hFFFF;
            end
         endcase
         sender_idle_pct = (phase < 2) ? 24 : (phase < 4) ? 59 : 0;
         receiver_idle_pct = (phase < 2) ? 59 : (phase < 4) ? 24 : 0;
         csr_write(lops_pkg::CSR_OWN_ID, {16'd0, own});
         csr_write(lops_pkg::CSR_INITIAL_LEFT, {16'd0, init_l});
         csr_write(lops_pkg::CSR_INITIAL_RIGHT, {16'd0, init_r});
         csr_write(lops_pkg::CSR_LEAVING_MODE, {31'd0, lv});

         sent = 0;
         while (sent < 130) begin
            // Long receiver stall while words keep coming, so the block backs up.
            if (phase == 1 && sent >= 40 && !held) begin
               hold_request = 1'b1;
               held = 1'b1;
            end
            // Sender pause until the block has handed back everything.
            if (phase == 3 && sent >= 60 && !paused) begin
               drain_outcomes();
               paused = 1'b1;
               @(posedge clock);
            end
            send_sequence(n);
            sent += n;
         end
      end

      // Let the last words come back, then watch for strays.
      drain_outcomes();
      repeat (8) @(posedge clock);
      if (awaited_outcomes.size() != 0) begin
         $display("%0t: %0d expected words never arrived", $time, awaited_outcomes.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
